@@ hw/rtl/plu_pkg.sv @@
// Shared types and constants of the palette line upscaler.
// No dependencies; imported by every module of the block.
package plu_pkg;

    // Field widths fixed by the pixel and write formats
    localparam int LINE_W  = 8;
    localparam int COL_W   = 8;
    localparam int CODE_W  = 8;
    localparam int ADDR_W  = 23;
    localparam int DATA_W  = 16;
    localparam int PITCH_W = 12;
    localparam int ORG_W   = 11;
    localparam int SCALE_W = 3;
    localparam int SHADE_W = 2;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_OUTPUT_ENABLE  = 3'd0;
    localparam logic [2:0] REG_WIDE_PIXELS    = 3'd1;
    localparam logic [2:0] REG_SCALE_FACTOR   = 3'd2;
    localparam logic [2:0] REG_ROW_PITCH      = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X       = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y       = 3'd5;
    localparam logic [2:0] REG_NARROW_PALETTE = 3'd6;
    localparam logic [2:0] REG_WIDE_PALETTE   = 3'd7;

    // Reset values of the registers
    localparam logic [PITCH_W-1:0] PITCH_RESET          = 12'd160;
    localparam logic [31:0]        NARROW_PALETTE_RESET = 32'h0049_B6FF;
    localparam logic [63:0]        WIDE_PALETTE_RESET   = 64'h0000_52AA_AD55_FFFF;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               enable;
        logic               wide;
        logic [PITCH_W-1:0] pitch;
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [31:0]        narrow_palette;
        logic [63:0]        wide_palette;
    } cfg_t;

    // One block of writes: address of its top-left element and its colour
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] colour;
    } blk_t;

endpackage

@@ hw/rtl/plu_front.sv @@
// Front end of the palette line upscaler: accepts pixels, drops the ones that
// draw nothing, looks up the colour and works out the block origin address.
// Depends on plu_pkg.
module plu_front #(
    parameter int LINE_PIXELS = 160,
    parameter int MAX_SCALE   = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  plu_pkg::cfg_t                         cfg,
    input  logic [$clog2(MAX_SCALE+1)-1:0]        scale,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [plu_pkg::LINE_W-1:0]            line_number,
    input  logic [plu_pkg::COL_W-1:0]             column,
    input  logic [plu_pkg::CODE_W-1:0]            pixel_code,
    output logic                                  push_valid,
    output plu_pkg::blk_t                         push_blk,
    input  logic                                  queue_full
);
    import plu_pkg::*;

    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int RW = ((LINE_W + SW > ORG_W) ? LINE_W + SW : ORG_W) + 1;
    localparam int XW = ((COL_W + SW > ORG_W) ? COL_W + SW : ORG_W) + 1;

    logic                a_valid_reg, a_valid_next;
    logic [RW-1:0]       a_row_reg, a_row_next;
    logic [XW-1:0]       a_colx_reg, a_colx_next;
    logic [DATA_W-1:0]   a_colour_reg, a_colour_next;

    logic                accept;
    logic                keep;
    logic                push;
    logic [SHADE_W-1:0]  shade;
    logic [RW+PITCH_W-1:0] row_prod;

    assign shade    = pixel_code[SHADE_W-1:0];
    assign in_ready = !a_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign keep     = cfg.enable && (int'(column) < LINE_PIXELS);
    assign push     = a_valid_reg && !queue_full;

    always_comb
    begin
        a_valid_next  = a_valid_reg;
        a_row_next    = a_row_reg;
        a_colx_next   = a_colx_reg;
        a_colour_next = a_colour_reg;
        if (push)
        begin
            a_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            a_valid_next = 1'b1;
            a_row_next   = RW'(cfg.origin_y) + RW'(line_number * scale);
            a_colx_next  = XW'(cfg.origin_x) + XW'(column * scale);
            if (cfg.wide)
            begin
                a_colour_next = cfg.wide_palette[shade*16 +: 16];
            end
            else
            begin
                a_colour_next = {8'd0, cfg.narrow_palette[shade*8 +: 8]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_row_reg    <= a_row_next;
        a_colx_reg   <= a_colx_next;
        a_colour_reg <= a_colour_next;
    end

    // row * pitch, one multiply, then the column offset; wraps at the address width
    assign row_prod        = (RW+PITCH_W)'(a_row_reg) * (RW+PITCH_W)'(cfg.pitch);
    assign push_valid      = a_valid_reg;
    assign push_blk.addr   = ADDR_W'(row_prod) + ADDR_W'(a_colx_reg);
    assign push_blk.colour = a_colour_reg;

endmodule

@@ hw/rtl/plu_queue.sv @@
// Short block queue between the front and back end of the upscaler.
// Depends on plu_pkg.
module plu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  plu_pkg::blk_t push_blk,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output plu_pkg::blk_t head
);
    import plu_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    blk_t            mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;

    assign full  = (int'(count_reg) == QUEUE_DEPTH);
    assign empty = (count_reg == '0);
    assign push  = push_valid && !full;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_blk;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count past depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count missed a push");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> rd_ptr_reg == wr_ptr_reg)
        else $error("empty queue with pointers apart");
`endif

endmodule

@@ hw/rtl/plu_back.sv @@
// Back end of the upscaler, depends on plu_pkg: walks each queued block row by row and
// drives one framebuffer write per cycle, while out_ready holds, via an output register.
module plu_back #(
    parameter int MAX_SCALE = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [plu_pkg::PITCH_W-1:0]         pitch,
    input  logic [$clog2(MAX_SCALE+1)-1:0]      scale,
    input  logic                                queue_empty,
    input  plu_pkg::blk_t                       head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [plu_pkg::ADDR_W-1:0]          out_addr,
    output logic [plu_pkg::DATA_W-1:0]          out_data,
    output logic                                out_last
);
    import plu_pkg::*;

    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int CW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    logic                busy_reg, busy_next;
    logic [CW-1:0]       dx_reg, dx_next;
    logic [CW-1:0]       dy_reg, dy_next;
    logic [ADDR_W-1:0]   row_addr_reg, row_addr_next;
    logic [DATA_W-1:0]   colour_reg, colour_next;

    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                advance;
    logic                emit;
    logic                dx_last;
    logic                dy_last;
    logic                is_last;

    assign advance = !out_valid_reg || out_ready;
    assign emit    = advance && busy_reg;
    assign dx_last = (SW'(dx_reg) == scale - SW'(1));
    assign dy_last = (SW'(dy_reg) == scale - SW'(1));
    assign is_last = dx_last && dy_last;
    assign pop     = advance && (!busy_reg || is_last) && !queue_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        row_addr_next  = row_addr_reg;
        colour_next    = colour_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
        end
        if (emit)
        begin
            out_addr_next = row_addr_reg + ADDR_W'(dx_reg);
            out_data_next = colour_reg;
            out_last_next = is_last;
            if (dx_last)
            begin
                dx_next       = '0;
                dy_next       = dy_reg + CW'(1);
                row_addr_next = row_addr_reg + ADDR_W'(pitch);
            end
            else
            begin
                dx_next = dx_reg + CW'(1);
            end
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        // next block starts right behind the last write of the current one
        if (pop)
        begin
            busy_next     = 1'b1;
            dx_next       = '0;
            dy_next       = '0;
            row_addr_next = head.addr;
            colour_next   = head.colour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_addr_reg <= row_addr_next;
        colour_reg   <= colour_next;
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("pop from empty queue");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !advance |=> $stable(dx_reg) && $stable(dy_reg) && $stable(row_addr_reg))
        else $error("block walk moved during stall");
    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        emit && is_last |=> out_valid_reg && out_last_reg)
        else $error("final write of block not marked");
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        emit && is_last && !pop |=> !busy_reg)
        else $error("block walk ran past its end");
`endif

endmodule

@@ hw/rtl/palette_line_upscaler.sv @@
// Top level of the palette line upscaler: register file, front end, block queue
// and back end. Depends on plu_pkg, plu_front, plu_queue and plu_back.
//
// Each pixel transfer on the s_ side (line, column, shade code) becomes an s-by-s
// block of framebuffer writes on the m_ side, s being scale_factor clamped to
// 1..MAX_SCALE. Writes come row by row, left to right, at element address
// (origin_y + line*s + dy)*row_pitch + origin_x + column*s + dx, wrapped to 23 bits,
// carrying the palette colour of the shade; tlast marks the final write of a block.
// A pixel becomes s*s writes, one write per cycle while m_tready is high; that rate is
// set by the back end's single write port, so at scale 1 a pixel passes every cycle.
// The front end (colour lookup, row*pitch multiply) runs ahead of the back end
// through a two-entry queue, so new pixels keep being taken while writes drain. Pixels
// with output disabled or a column at or beyond LINE_PIXELS are taken and dropped;
// others go through the front-end register and the queue to the output register.
// Registers sit on an APB port at byte address 8*index, 64-bit data, pready always
// high; they are to be changed only while no writes are pending.
module palette_line_upscaler #(
    parameter int LINE_PIXELS = 160,
    parameter int MAX_SCALE   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // line_number[7:0], column[15:8], pixel_code[23:16]
    // framebuffer writes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // write_address[22:0], write_data[38:23], zero[39]
    output logic        m_tlast    // last_write
);
    import plu_pkg::*;

    localparam int SW = $clog2(MAX_SCALE + 1);

    logic                 enable_reg;
    logic                 wide_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [PITCH_W-1:0]   pitch_reg;
    logic [ORG_W-1:0]     origin_x_reg;
    logic [ORG_W-1:0]     origin_y_reg;
    logic [31:0]          narrow_pal_reg;
    logic [63:0]          wide_pal_reg;

    logic [2:0]           reg_index;
    logic                 cfg_write;
    cfg_t                 cfg;
    logic [SW-1:0]        scale_eff;

    logic                 push_valid;
    blk_t                 push_blk;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 pop;
    blk_t                 head;

    logic [ADDR_W-1:0]    out_addr;
    logic [DATA_W-1:0]    out_data;

    // ---------------------------------------------------------------- registers
    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            wide_reg       <= 1'b0;
            scale_reg      <= SCALE_W'(1);
            pitch_reg      <= PITCH_RESET;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            narrow_pal_reg <= NARROW_PALETTE_RESET;
            wide_pal_reg   <= WIDE_PALETTE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_OUTPUT_ENABLE:  enable_reg     <= pwdata[0];
                REG_WIDE_PIXELS:    wide_reg       <= pwdata[0];
                REG_SCALE_FACTOR:   scale_reg      <= pwdata[SCALE_W-1:0];
                REG_ROW_PITCH:      pitch_reg      <= pwdata[PITCH_W-1:0];
                REG_ORIGIN_X:       origin_x_reg   <= pwdata[ORG_W-1:0];
                REG_ORIGIN_Y:       origin_y_reg   <= pwdata[ORG_W-1:0];
                REG_NARROW_PALETTE: narrow_pal_reg <= pwdata[31:0];
                REG_WIDE_PALETTE:   wide_pal_reg   <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_OUTPUT_ENABLE:  prdata = 64'(enable_reg);
            REG_WIDE_PIXELS:    prdata = 64'(wide_reg);
            REG_SCALE_FACTOR:   prdata = 64'(scale_reg);
            REG_ROW_PITCH:      prdata = 64'(pitch_reg);
            REG_ORIGIN_X:       prdata = 64'(origin_x_reg);
            REG_ORIGIN_Y:       prdata = 64'(origin_y_reg);
            REG_NARROW_PALETTE: prdata = 64'(narrow_pal_reg);
            REG_WIDE_PALETTE:   prdata = wide_pal_reg;
            default:            prdata = '0;
        endcase
    end

    // scale zero acts as one, anything above the maximum saturates
    always_comb
    begin
        priority if (scale_reg == '0)
        begin
            scale_eff = SW'(1);
        end
        else if (int'(scale_reg) > MAX_SCALE)
        begin
            scale_eff = SW'(MAX_SCALE);
        end
        else
        begin
            scale_eff = SW'(scale_reg);
        end
    end

    assign cfg.enable         = enable_reg;
    assign cfg.wide           = wide_reg;
    assign cfg.pitch          = pitch_reg;
    assign cfg.origin_x       = origin_x_reg;
    assign cfg.origin_y       = origin_y_reg;
    assign cfg.narrow_palette = narrow_pal_reg;
    assign cfg.wide_palette   = wide_pal_reg;

    // ---------------------------------------------------------------- datapath
    plu_front #(
        .LINE_PIXELS (LINE_PIXELS),
        .MAX_SCALE   (MAX_SCALE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .scale       (scale_eff),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .line_number (s_tdata[7:0]),
        .column      (s_tdata[15:8]),
        .pixel_code  (s_tdata[23:16]),
        .push_valid  (push_valid),
        .push_blk    (push_blk),
        .queue_full  (queue_full)
    );

    plu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_blk   (push_blk),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    plu_back #(
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pitch       (pitch_reg),
        .scale       (scale_eff),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_addr    (out_addr),
        .out_data    (out_data),
        .out_last    (m_tlast)
    );

    assign m_tdata = {1'b0, out_data, out_addr};

endmodule
